### rtl/grb_pkg.sv
// ----------------------------------------------------------------------------
// grb_pkg: shared types and constants of the GPIO register block.
// Holds the register index codes, the field widths and the payload structs
// of the request and response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grb_pkg;

  // Field widths fixed by the bus and pad interface.
  localparam int unsigned PAD_W    = 54;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned BANK_W   = 32;
  localparam int unsigned WIDE_W   = 2 * BANK_W;

  // Function select layout: six words of ten 3-bit codes.
  localparam int unsigned FSEL_WORDS         = 6;
  localparam int unsigned FSEL_PINS_PER_WORD = 10;
  localparam int unsigned FSEL_CODE_W        = 3;
  localparam int unsigned FSEL_WORD_W        = FSEL_PINS_PER_WORD * FSEL_CODE_W;
  localparam int unsigned FSEL_IDX_W         = $clog2(FSEL_WORDS);
  localparam int unsigned FSEL_PIN_LIMIT     = FSEL_WORDS * FSEL_PINS_PER_WORD;

  localparam logic [FSEL_CODE_W-1:0] FSEL_OUTPUT = 3'd1;

  // Pull control codes.
  localparam int unsigned PULL_W = 2;
  localparam logic [PULL_W-1:0] PULL_NONE = 2'd0;
  localparam logic [PULL_W-1:0] PULL_DOWN = 2'd1;
  localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

  // Access kinds.
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam int unsigned DEFAULT_PIN_COUNT = 54;

  // Register map.
  typedef enum logic [IDX_W-1:0] {
    REG_FSEL0   = 4'd0,
    REG_FSEL1   = 4'd1,
    REG_FSEL2   = 4'd2,
    REG_FSEL3   = 4'd3,
    REG_FSEL4   = 4'd4,
    REG_FSEL5   = 4'd5,
    REG_SET0    = 4'd6,
    REG_SET1    = 4'd7,
    REG_CLR0    = 4'd8,
    REG_CLR1    = 4'd9,
    REG_LEV0    = 4'd10,
    REG_LEV1    = 4'd11,
    REG_PULL    = 4'd12,
    REG_PCLK0   = 4'd13,
    REG_PCLK1   = 4'd14,
    REG_INVALID = 4'd15
  } grb_reg_e;

  // Request payload.
  typedef struct packed {
    logic              mode;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic [PAD_W-1:0]  pad_levels;
  } grb_in_t;

  // Response payload.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              access_error;
    logic [PAD_W-1:0]  pad_drive;
    logic [PAD_W-1:0]  pad_drive_enable;
    logic [PAD_W-1:0]  pad_pull_up;
    logic [PAD_W-1:0]  pad_pull_down;
  } grb_out_t;

  // One bus access as seen by the register file.
  typedef struct packed {
    logic              fire;
    logic              write;
    grb_reg_e          reg_index;
    logic [DATA_W-1:0] write_data;
  } grb_access_t;

endpackage

`default_nettype wire

### rtl/grb_regfile.sv
// ----------------------------------------------------------------------------
// grb_regfile: architectural state of the GPIO register block.
// Decodes one access per cycle, updates the function select, output latch,
// pull control and pull clock registers, and presents the pad view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grb_regfile #(
  parameter int unsigned PIN_COUNT = grb_pkg::DEFAULT_PIN_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire grb_pkg::grb_access_t          acc,
  input  wire logic [grb_pkg::PAD_W-1:0]     pad_levels,
  output logic      [grb_pkg::DATA_W-1:0]    rd_data,
  output logic                               acc_err,
  output logic      [grb_pkg::PAD_W-1:0]     pad_drive,
  output logic      [grb_pkg::PAD_W-1:0]     pad_drive_enable,
  output logic      [grb_pkg::PAD_W-1:0]     pad_pull_up,
  output logic      [grb_pkg::PAD_W-1:0]     pad_pull_down
);

  localparam int unsigned PW = PIN_COUNT;

  logic [grb_pkg::FSEL_WORD_W-1:0] fsel_r   [grb_pkg::FSEL_WORDS];
  logic [grb_pkg::FSEL_WORD_W-1:0] fsel_nxt [grb_pkg::FSEL_WORDS];
  logic [PW-1:0]                   latch_r, latch_nxt;
  logic [PW-1:0]                   pclk_r, pclk_nxt;
  logic [grb_pkg::PULL_W-1:0]      pctl_r, pctl_nxt;
  logic [grb_pkg::PULL_W-1:0]      pstate_r   [PW];
  logic [grb_pkg::PULL_W-1:0]      pstate_nxt [PW];

  logic                            bank_a;
  logic                            bank_p;
  logic [PW-1:0]                   pads_pw;
  logic [grb_pkg::WIDE_W-1:0]      pads_w;
  logic [grb_pkg::WIDE_W-1:0]      pclk_w;
  logic [PW-1:0]                   wbits_a;
  logic [PW-1:0]                   wbits_p;
  logic [PW-1:0]                   pmask_p;
  logic [PW-1:0]                   pclk_new;
  logic [PW-1:0]                   rise;
  logic                            pclk_wr;
  logic [PW-1:0]                   en_pw;
  logic [PW-1:0]                   up_pw;
  logic [PW-1:0]                   dn_pw;

  // Set, clear and level registers use bank = index bit 0; the pull clock
  // pair starts on an odd index, so its bank is the inverse.
  assign bank_a = acc.reg_index[0];
  assign bank_p = !acc.reg_index[0];

  // Pins beyond the pin count are dropped.
  assign pads_pw = PW'(pad_levels);
  assign pads_w  = grb_pkg::WIDE_W'(pads_pw);
  assign pclk_w  = grb_pkg::WIDE_W'(pclk_r);

  assign wbits_a = PW'(bank_a ? {acc.write_data, grb_pkg::BANK_W'(0)}
                              : {grb_pkg::BANK_W'(0), acc.write_data});
  assign wbits_p = PW'(bank_p ? {acc.write_data, grb_pkg::BANK_W'(0)}
                              : {grb_pkg::BANK_W'(0), acc.write_data});
  assign pmask_p = PW'(bank_p ? {{grb_pkg::BANK_W{1'b1}}, grb_pkg::BANK_W'(0)}
                              : {grb_pkg::BANK_W'(0), {grb_pkg::BANK_W{1'b1}}});

  assign pclk_new = (pclk_r & ~pmask_p) | wbits_p;
  assign rise     = pclk_new & ~pclk_r;
  assign pclk_wr  = acc.fire && acc.write &&
                    (acc.reg_index == grb_pkg::REG_PCLK0 ||
                     acc.reg_index == grb_pkg::REG_PCLK1);

  // Register updates and read mux.
  always_comb begin
    fsel_nxt  = fsel_r;
    latch_nxt = latch_r;
    pclk_nxt  = pclk_r;
    pctl_nxt  = pctl_r;
    rd_data   = '0;
    acc_err   = 1'b0;
    unique case (acc.reg_index)
      grb_pkg::REG_FSEL0, grb_pkg::REG_FSEL1, grb_pkg::REG_FSEL2,
      grb_pkg::REG_FSEL3, grb_pkg::REG_FSEL4, grb_pkg::REG_FSEL5: begin
        if (acc.write) begin
          fsel_nxt[acc.reg_index[grb_pkg::FSEL_IDX_W-1:0]] =
            acc.write_data[grb_pkg::FSEL_WORD_W-1:0];
        end else begin
          rd_data = grb_pkg::DATA_W'(fsel_r[acc.reg_index[grb_pkg::FSEL_IDX_W-1:0]]);
        end
      end
      grb_pkg::REG_SET0, grb_pkg::REG_SET1: begin
        if (acc.write) begin
          latch_nxt = latch_r | wbits_a;
        end
      end
      grb_pkg::REG_CLR0, grb_pkg::REG_CLR1: begin
        if (acc.write) begin
          latch_nxt = latch_r & ~wbits_a;
        end
      end
      grb_pkg::REG_LEV0, grb_pkg::REG_LEV1: begin
        if (!acc.write) begin
          rd_data = bank_a ? pads_w[grb_pkg::WIDE_W-1:grb_pkg::BANK_W]
                           : pads_w[grb_pkg::BANK_W-1:0];
        end
      end
      grb_pkg::REG_PULL: begin
        if (acc.write) begin
          pctl_nxt = acc.write_data[grb_pkg::PULL_W-1:0];
        end else begin
          rd_data = grb_pkg::DATA_W'(pctl_r);
        end
      end
      grb_pkg::REG_PCLK0, grb_pkg::REG_PCLK1: begin
        if (acc.write) begin
          pclk_nxt = pclk_new;
        end else begin
          rd_data = bank_p ? pclk_w[grb_pkg::WIDE_W-1:grb_pkg::BANK_W]
                           : pclk_w[grb_pkg::BANK_W-1:0];
        end
      end
      grb_pkg::REG_INVALID: begin
        acc_err = 1'b1;
      end
      default: begin
        acc_err = 1'b1;
      end
    endcase
  end

  // A rising pull clock bit latches the current pull control into that pin.
  always_comb begin
    for (int unsigned p = 0; p < PW; p++) begin
      pstate_nxt[p] = (pclk_wr && rise[p]) ? pctl_r : pstate_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned w = 0; w < grb_pkg::FSEL_WORDS; w++) begin
        fsel_r[w] <= '0;
      end
      for (int unsigned p = 0; p < PW; p++) begin
        pstate_r[p] <= grb_pkg::PULL_NONE;
      end
      latch_r <= '0;
      pclk_r  <= '0;
      pctl_r  <= grb_pkg::PULL_NONE;
    end else if (acc.fire) begin
      fsel_r   <= fsel_nxt;
      pstate_r <= pstate_nxt;
      latch_r  <= latch_nxt;
      pclk_r   <= pclk_nxt;
      pctl_r   <= pctl_nxt;
    end
  end

  // Pad view. Pins without a select word never drive.
  for (genvar p = 0; p < PW; p++) begin : g_pin
    if (p < grb_pkg::FSEL_PIN_LIMIT) begin : g_fsel
      assign en_pw[p] =
        fsel_r[p / grb_pkg::FSEL_PINS_PER_WORD]
              [(p % grb_pkg::FSEL_PINS_PER_WORD) * grb_pkg::FSEL_CODE_W +:
               grb_pkg::FSEL_CODE_W] == grb_pkg::FSEL_OUTPUT;
    end else begin : g_nofsel
      assign en_pw[p] = 1'b0;
    end
    assign up_pw[p] = (pstate_r[p] == grb_pkg::PULL_UP);
    assign dn_pw[p] = (pstate_r[p] == grb_pkg::PULL_DOWN);
  end

  assign pad_drive        = grb_pkg::PAD_W'(latch_r);
  assign pad_drive_enable = grb_pkg::PAD_W'(en_pw);
  assign pad_pull_up      = grb_pkg::PAD_W'(up_pw);
  assign pad_pull_down    = grb_pkg::PAD_W'(dn_pw);

endmodule

`default_nettype wire

### rtl/gpio_register_block_top.sv
// A response is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle while no response is held; the single
// response register is refilled in the same cycle its current content is taken.
// Reset: synchronous, active low; clears the register file to zero (all pins
// inputs, output latch low, no pulls) and empties the response register.
// ----------------------------------------------------------------------------
// gpio_register_block_top: GPIO register block for up to 54 pins.
// Each request is one register read or write; each response carries the
// read word, an error flag and the resulting pad drive and pull view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpio_register_block_top #(
  parameter int unsigned PIN_COUNT = grb_pkg::DEFAULT_PIN_COUNT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Request channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire grb_pkg::grb_in_t  in_data,
  // Response channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output grb_pkg::grb_out_t      out_data
);

  grb_pkg::grb_access_t         acc;
  logic                         fire;
  logic                         out_valid_r, out_valid_nxt;
  logic [grb_pkg::DATA_W-1:0]   rd_data;
  logic                         acc_err;
  logic [grb_pkg::DATA_W-1:0]   rd_r;
  logic                         err_r;
  logic [grb_pkg::PAD_W-1:0]    pad_drive;
  logic [grb_pkg::PAD_W-1:0]    pad_drive_enable;
  logic [grb_pkg::PAD_W-1:0]    pad_pull_up;
  logic [grb_pkg::PAD_W-1:0]    pad_pull_down;

  // The response register holds one result. A new request is taken whenever
  // that register is empty or is being drained in the same cycle.
  assign in_stall = out_valid_r && out_stall;
  assign fire     = in_valid && !in_stall;

  assign acc.fire       = fire;
  assign acc.write      = (in_data.mode == grb_pkg::MODE_WRITE);
  assign acc.reg_index  = grb_pkg::grb_reg_e'(in_data.reg_index);
  assign acc.write_data = in_data.write_data;

  grb_regfile #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regfile (
    .clk              (clk),
    .rst_n            (rst_n),
    .acc              (acc),
    .pad_levels       (in_data.pad_levels),
    .rd_data          (rd_data),
    .acc_err          (acc_err),
    .pad_drive        (pad_drive),
    .pad_drive_enable (pad_drive_enable),
    .pad_pull_up      (pad_pull_up),
    .pad_pull_down    (pad_pull_down)
  );

  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read word and error flag are captured with the transfer.
  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r  <= rd_data;
      err_r <= acc_err;
    end
  end

  // The pad view comes straight from the state registers. They only change
  // on a request transfer, and no transfer happens while a response is held,
  // so the view always matches the response being presented.
  assign out_valid                 = out_valid_r;
  assign out_data.read_data        = rd_r;
  assign out_data.access_error     = err_r;
  assign out_data.pad_drive        = pad_drive;
  assign out_data.pad_drive_enable = pad_drive_enable;
  assign out_data.pad_pull_up      = pad_pull_up;
  assign out_data.pad_pull_down    = pad_pull_down;

endmodule

`default_nettype wire

### rtl/grb_checker.sv
// ----------------------------------------------------------------------------
// grb_checker: port-level checks for the GPIO register block.
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grb_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire grb_pkg::grb_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire grb_pkg::grb_out_t out_data
);

  // A held response keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  // The request side only stalls behind a pending response.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("request stalled with no response pending");

  // An access to the unused index returns an error on the next response.
  a_invalid_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.reg_index == grb_pkg::REG_INVALID
    |=> out_valid && out_data.access_error && out_data.read_data == '0)
    else $error("unused index did not raise an error");

  // Writes and reads of write-only registers return a zero word.
  a_zero_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.mode == grb_pkg::MODE_WRITE ||
     in_data.reg_index == grb_pkg::REG_SET0 ||
     in_data.reg_index == grb_pkg::REG_SET1 ||
     in_data.reg_index == grb_pkg::REG_CLR0 ||
     in_data.reg_index == grb_pkg::REG_CLR1)
    |=> out_valid && out_data.read_data == '0)
    else $error("nonzero read word for a write or write-only register");

endmodule

bind gpio_register_block_top grb_checker u_grb_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the GPIO register block.
// Feeds directed and random register reads and writes through the request
// channel, predicts every response with an internal copy of the registers,
// and compares each response field by field as it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import grb_pkg::*;

  localparam int unsigned PIN_COUNT      = DEFAULT_PIN_COUNT;
  localparam logic [63:0] PIN_MASK       = (PIN_COUNT >= 64) ? '1 :
                                           ((64'd1 << PIN_COUNT) - 64'd1);
  localparam logic [FSEL_WORD_W-1:0] ALL_OUTPUT_WORD = {FSEL_PINS_PER_WORD{FSEL_OUTPUT}};
  localparam int unsigned RANDOM_PER_PHASE = 545;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  grb_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  grb_out_t out_data;

  gpio_register_block_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 12 ns clock period.
  always #6 clk = ~clk;

  // Accesses waiting to be driven, and responses predicted for accesses that
  // have already made their transfer.
  grb_in_t  pending_requests[$];
  grb_out_t expected_responses[$];

  // Idle percentages of the two sides; the stimulus process steps them
  // through the three traffic phases.
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 47;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  grb_out_t    predicted_rsp;
  grb_out_t    oldest_rsp;

  // Shadow copy of the register block, reset state as declared.
  logic [FSEL_WORD_W-1:0] shadow_fsel [FSEL_WORDS] = '{default: '0};
  logic [63:0]            shadow_latch = '0;
  logic [PULL_W-1:0]      shadow_pull_code = PULL_NONE;
  logic [63:0]            shadow_pull_clock = '0;
  logic [PULL_W-1:0]      shadow_pin_pull [PIN_COUNT] = '{default: PULL_NONE};

  // Places a 32-bit bank word at its bank position, dropping absent pins.
  function automatic logic [63:0] bank_bits(input logic [31:0] word, input int unsigned bank);
    return ({32'd0, word} << (bank * BANK_W)) & PIN_MASK;
  endfunction

  // Applies one access to the shadow registers and builds the response that
  // the block must return for it.
  task automatic apply_gpio_access(input grb_in_t req, output grb_out_t rsp);
    grb_reg_e    idx;
    logic        wr;
    logic [63:0] pads;
    logic [63:0] new_word;
    logic [63:0] rise;
    logic [63:0] en;
    logic [63:0] up;
    logic [63:0] dn;
    logic [31:0] rd;
    logic        err;
    int unsigned bank;
    idx  = grb_reg_e'(req.reg_index);
    wr   = (req.mode == MODE_WRITE);
    pads = {{(64 - PAD_W){1'b0}}, req.pad_levels} & PIN_MASK;
    rd   = '0;
    err  = 1'b0;
    en   = '0;
    up   = '0;
    dn   = '0;
    case (idx)
      REG_FSEL0, REG_FSEL1, REG_FSEL2, REG_FSEL3, REG_FSEL4, REG_FSEL5: begin
        if (wr) begin
          shadow_fsel[req.reg_index[FSEL_IDX_W-1:0]] = req.write_data[FSEL_WORD_W-1:0];
        end else begin
          rd = {{(DATA_W - FSEL_WORD_W){1'b0}}, shadow_fsel[req.reg_index[FSEL_IDX_W-1:0]]};
        end
      end
      // Set and clear registers are write-only and read back as zero.
      REG_SET0, REG_SET1: begin
        if (wr) shadow_latch |= bank_bits(req.write_data, 32'(idx - REG_SET0));
      end
      REG_CLR0, REG_CLR1: begin
        if (wr) shadow_latch &= ~bank_bits(req.write_data, 32'(idx - REG_CLR0));
      end
      // Level registers are read-only; a write is silently dropped.
      REG_LEV0, REG_LEV1: begin
        if (!wr) rd = pads[(idx - REG_LEV0) * BANK_W +: BANK_W];
      end
      REG_PULL: begin
        if (wr) begin
          shadow_pull_code = req.write_data[PULL_W-1:0];
        end else begin
          rd = {{(DATA_W - PULL_W){1'b0}}, shadow_pull_code};
        end
      end
      REG_PCLK0, REG_PCLK1: begin
        bank = 32'(idx - REG_PCLK0);
        if (wr) begin
          // The bank word is replaced; only rising bits latch the pull code.
          new_word = (shadow_pull_clock & ~bank_bits('1, bank))
                     | bank_bits(req.write_data, bank);
          rise = new_word & ~shadow_pull_clock;
          for (int p = 0; p < PIN_COUNT; p++) begin
            if (rise[p]) shadow_pin_pull[p] = shadow_pull_code;
          end
          shadow_pull_clock = new_word;
        end else begin
          rd = shadow_pull_clock[bank * BANK_W +: BANK_W];
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    for (int p = 0; p < PIN_COUNT; p++) begin
      if (p < FSEL_PIN_LIMIT &&
          shadow_fsel[p / FSEL_PINS_PER_WORD][(p % FSEL_PINS_PER_WORD) * FSEL_CODE_W +:
                                             FSEL_CODE_W] == FSEL_OUTPUT) begin
        en[p] = 1'b1;
      end
      // Pull code 3 is stored but drives neither pull direction.
      if (shadow_pin_pull[p] == PULL_UP) begin
        up[p] = 1'b1;
      end else if (shadow_pin_pull[p] == PULL_DOWN) begin
        dn[p] = 1'b1;
      end
    end
    rsp.read_data        = rd;
    rsp.access_error     = err;
    rsp.pad_drive        = shadow_latch[PAD_W-1:0];
    rsp.pad_drive_enable = en[PAD_W-1:0];
    rsp.pad_pull_up      = up[PAD_W-1:0];
    rsp.pad_pull_down    = dn[PAD_W-1:0];
  endtask

  task automatic check_field(input string field_name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("[%0t] %s mismatch: expected %h, got %h", $realtime, field_name, want, got);
      end
    end
  endtask

  // Request driver. A transfer happens at an edge where valid is high and
  // stall is low; the accepted access is predicted right there. The payload
  // is only replaced once the current one has been taken, and every path
  // makes at most one assignment to valid.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_gpio_access(in_data, predicted_rsp);
        expected_responses.push_back(predicted_rsp);
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor. Every response transfer is matched against the oldest
  // prediction. The same block throttles the response side and runs the
  // watchdog, which ends the run after too many cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] response transfer with nothing expected: %h", $realtime, out_data);
          end
        end else begin
          oldest_rsp = expected_responses.pop_front();
          check_field("read_data", 64'(oldest_rsp.read_data), 64'(out_data.read_data));
          check_field("access_error", 64'(oldest_rsp.access_error),
                      64'(out_data.access_error));
          check_field("pad_drive", 64'(oldest_rsp.pad_drive), 64'(out_data.pad_drive));
          check_field("pad_drive_enable", 64'(oldest_rsp.pad_drive_enable),
                      64'(out_data.pad_drive_enable));
          check_field("pad_pull_up", 64'(oldest_rsp.pad_pull_up), 64'(out_data.pad_pull_up));
          check_field("pad_pull_down", 64'(oldest_rsp.pad_pull_down),
                      64'(out_data.pad_pull_down));
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_access(input logic mode, input grb_reg_e idx,
                              input logic [DATA_W-1:0] data, input logic [PAD_W-1:0] pads);
    grb_in_t req;
    req.mode       = mode;
    req.reg_index  = idx;
    req.write_data = data;
    req.pad_levels = pads;
    pending_requests.push_back(req);
  endtask

  // Random access. Write data is drawn so that function words often hold
  // output codes and the pull-clock banks toggle, which keeps the enable and
  // pull views moving.
  task automatic queue_random_access();
    grb_in_t     req;
    int unsigned pick;
    req.mode       = ($urandom_range(99) < 60) ? MODE_WRITE : MODE_READ;
    req.reg_index  = IDX_W'($urandom_range(15));
    req.pad_levels = PAD_W'({$urandom, $urandom});
    pick = $urandom_range(9);
    case (pick)
      0: req.write_data = '1;
      1: req.write_data = '0;
      2, 3: begin
        req.write_data = $urandom;
        for (int k = 0; k < FSEL_PINS_PER_WORD; k++) begin
          if ($urandom_range(2) != 0) begin
            req.write_data[k * FSEL_CODE_W +: FSEL_CODE_W] =
              $urandom_range(1) ? FSEL_OUTPUT : '0;
          end
        end
      end
      default: req.write_data = $urandom;
    endcase
    pending_requests.push_back(req);
  endtask

  // Waits at falling edges so that queue state and valid are both settled.
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || in_valid || expected_responses.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Stimulus: reset, a directed pass over every register and corner, then
  // three random phases with different idle patterns.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values, then function words: upper bits of a full word dropped,
    // all-output words, including the last word whose upper pins are absent.
    queue_access(MODE_READ, REG_FSEL0, '1, '1);
    queue_access(MODE_WRITE, REG_FSEL0, '1, '0);
    queue_access(MODE_READ, REG_FSEL0, '0, '0);
    queue_access(MODE_WRITE, REG_FSEL1, 32'(ALL_OUTPUT_WORD), '1);
    queue_access(MODE_WRITE, REG_FSEL2, 32'(ALL_OUTPUT_WORD), '0);
    queue_access(MODE_WRITE, REG_FSEL3, 32'(ALL_OUTPUT_WORD), '0);
    queue_access(MODE_WRITE, REG_FSEL4, '1, '0);
    queue_access(MODE_WRITE, REG_FSEL5, 32'hFFFF_FFFF ^ 32'(~ALL_OUTPUT_WORD), '0);
    queue_access(MODE_READ, REG_FSEL5, '0, '0);
    // Output latch: full set of both banks, write-only reads, a partial clear of bank 0, a full clear of bank 1.
    queue_access(MODE_WRITE, REG_SET0, '1, '0);
    queue_access(MODE_WRITE, REG_SET1, '1, '0);
    queue_access(MODE_READ, REG_SET1, '1, '1);
    queue_access(MODE_WRITE, REG_CLR0, 32'h5555_5555, '0);
    queue_access(MODE_WRITE, REG_CLR1, '1, '0);
    queue_access(MODE_READ, REG_CLR0, '1, '1);
    // Level banks read the pads; a write to a level register changes nothing.
    queue_access(MODE_READ, REG_LEV0, '0, '1);
    queue_access(MODE_READ, REG_LEV1, '0, '1);
    queue_access(MODE_WRITE, REG_LEV0, '1, '1);
    // Pull latching: up on bank 0, down on bank 1, code 3 after a clear.
    queue_access(MODE_WRITE, REG_PULL, 32'hFFFF_FFFE, '0);
    queue_access(MODE_WRITE, REG_PCLK0, '1, '0);
    queue_access(MODE_WRITE, REG_PULL, 32'(PULL_DOWN), '0);
    queue_access(MODE_WRITE, REG_PCLK1, '1, '0);
    queue_access(MODE_READ, REG_PCLK1, '0, '0);
    queue_access(MODE_WRITE, REG_PCLK0, '0, '0);
    queue_access(MODE_WRITE, REG_PULL, '1, '0);
    queue_access(MODE_WRITE, REG_PCLK0, 32'h0000_FFFF, '0);
    queue_access(MODE_READ, REG_PULL, '0, '0);
    // An invalid index flags an error on both access kinds.
    queue_access(MODE_READ, REG_INVALID, '1, '1);
    queue_access(MODE_WRITE, REG_INVALID, '1, '1);
    wait_for_drain();

    // Sender lighter, receiver heavier; then swapped; then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 32 : 0;
      repeat (RANDOM_PER_PHASE) queue_random_access();
      wait_for_drain();
    end

    // Nothing is outstanding; give the block its latency to show any stray
    // response before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### gpio_register_block_top.f
rtl/grb_pkg.sv
rtl/grb_regfile.sv
rtl/gpio_register_block_top.sv
rtl/grb_checker.sv
tb/sv/tb.sv
